@@ rtl/mtc_pkg.sv @@
package mtc_pkg;

	localparam int MAX_ITEMS_DEF  = 256;
	localparam int VALUE_BITS_DEF = 16;

	// fixed field widths on the ports
	localparam int IN_VALUE_W = 16;
	localparam int TOTAL_W    = 22;
	localparam int OUT_DATA_W = 24;

	localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};

	// control bits that travel with an item along the chain
	typedef struct packed {
		logic valid;
		logic last;
		logic ovf;
	} ctl_t;

	function automatic logic [TOTAL_W-1:0] sat_add(input logic [TOTAL_W-1:0] a,
			input logic [TOTAL_W-1:0] b);
		logic [TOTAL_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[TOTAL_W] ? TOTAL_MAX : s[TOTAL_W-1:0];
	endfunction

endpackage

@@ rtl/mtc_cell.sv @@
module mtc_cell #(
	parameter int MAX_ITEMS  = 256,
	parameter int VALUE_BITS = 16,
	parameter int CELL_IDX   = 0,
	localparam int PW = $clog2(MAX_ITEMS + 1),
	localparam int CW = $clog2(MAX_ITEMS)
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     adv,
	input  mtc_pkg::ctl_t            ctl_i,
	input  logic [VALUE_BITS-1:0]    value_i,
	input  logic [PW-1:0]            pos_i,
	input  logic [mtc_pkg::TOTAL_W-1:0] sum_i,
	input  logic [CW-1:0]            below_i,
	input  logic [CW-1:0]            above_i,
	output mtc_pkg::ctl_t            ctl_o,
	output logic [VALUE_BITS-1:0]    value_o,
	output logic [PW-1:0]            pos_o,
	output logic [mtc_pkg::TOTAL_W-1:0] sum_o,
	output logic [CW-1:0]            below_o,
	output logic [CW-1:0]            above_o
);
	import mtc_pkg::*;

	localparam logic [PW-1:0] IDX = PW'(CELL_IDX);

	logic [VALUE_BITS-1:0] entry_value_q;
	logic [CW-1:0]         entry_below_q;
	logic [CW-1:0]         entry_above_q;

	ctl_t                  ctl_s1;
	logic [VALUE_BITS-1:0] value_s1;
	logic [PW-1:0]         pos_s1;
	logic [TOTAL_W-1:0]    sum_s1;
	logic [CW-1:0]         below_s1;
	logic [CW-1:0]         above_s1;

	logic               hit;
	logic               store;
	logic               lt;
	logic               gt;
	logic [CW-1:0]      add_cnt;
	logic [TOTAL_W-1:0] sum_next;

	// this entry holds an earlier value of the sequence when its slot is below the item's
	assign hit   = ctl_i.valid && !ctl_i.ovf && (pos_i > IDX);
	assign store = ctl_i.valid && !ctl_i.ovf && (pos_i == IDX);
	assign lt    = entry_value_q < value_i;
	assign gt    = entry_value_q > value_i;

	always_comb begin
		add_cnt = '0;
		if (hit && lt) begin
			add_cnt = entry_below_q;
		end else if (hit && gt) begin
			add_cnt = entry_above_q;
		end
		sum_next = sat_add(sum_i, TOTAL_W'(add_cnt));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else if (adv) begin
			ctl_s1 <= ctl_i;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			value_s1 <= value_i;
			pos_s1   <= pos_i;
			sum_s1   <= sum_next;
			below_s1 <= below_i + CW'(hit && lt);
			above_s1 <= above_i + CW'(hit && gt);
		end
		if (adv && store) begin
			entry_value_q <= value_i;
			entry_below_q <= below_i;
			entry_above_q <= above_i;
		end
	end

	assign ctl_o   = ctl_s1;
	assign value_o = value_s1;
	assign pos_o   = pos_s1;
	assign sum_o   = sum_s1;
	assign below_o = below_s1;
	assign above_o = above_s1;

endmodule

@@ rtl/monotone_triple_counter_core.sv @@
// channel  dir  handshake            payload
// s_*      in   s_tvalid/s_tready    s_tdata = value, s_tlast = last
// m_*      out  m_tvalid/m_tready    m_tdata = team_count, m_tuser = overflow,
//                                    m_tlast = last_res
//
// One item enters per cycle. Each item walks a chain of MAX_ITEMS cells, one cell
// per cycle; it is registered at the entry, in every cell and again at the output.
// Cell j holds the j-th value of the sequence; items reach cells in order, so an
// entry is always written before a later item reads it. No clearing pass after reset.
// A stalled output freezes the whole chain and drops s_tready.
module monotone_triple_counter_core #(
	parameter int MAX_ITEMS  = mtc_pkg::MAX_ITEMS_DEF,
	parameter int VALUE_BITS = mtc_pkg::VALUE_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [mtc_pkg::IN_VALUE_W-1:0] s_tdata,  // [15:0] value
	input  logic                          s_tlast,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [mtc_pkg::OUT_DATA_W-1:0] m_tdata,  // [21:0] team_count, [23:22] zero
	output logic                          m_tuser,  // [0] overflow
	output logic                          m_tlast
);
	import mtc_pkg::*;

	localparam int PW = $clog2(MAX_ITEMS + 1);
	localparam int CW = $clog2(MAX_ITEMS);
	localparam logic [PW-1:0] FULL = PW'(MAX_ITEMS);

	logic                  adv;
	logic                  accept;
	logic [VALUE_BITS-1:0] in_value;
	logic                  in_ovf;

	logic [PW-1:0]         fill_q;
	logic                  ovf_seen_q;
	logic [TOTAL_W-1:0]    total_q;

	ctl_t                  ctl_s1;
	logic [VALUE_BITS-1:0] value_s1;
	logic [PW-1:0]         pos_s1;

	ctl_t                  ctl_c   [MAX_ITEMS+1];
	logic [VALUE_BITS-1:0] value_c [MAX_ITEMS+1];
	logic [PW-1:0]         pos_c   [MAX_ITEMS+1];
	logic [TOTAL_W-1:0]    sum_c   [MAX_ITEMS+1];
	logic [CW-1:0]         below_c [MAX_ITEMS+1];
	logic [CW-1:0]         above_c [MAX_ITEMS+1];

	logic                  out_valid_q;
	logic [TOTAL_W-1:0]    team_q;
	logic                  out_ovf_q;
	logic                  out_last_q;
	logic [TOTAL_W-1:0]    result;

	assign adv      = !out_valid_q || m_tready;
	assign s_tready = adv;
	assign accept   = s_tvalid && adv;

	if (VALUE_BITS <= IN_VALUE_W) begin : g_val_trunc
		assign in_value = s_tdata[VALUE_BITS-1:0];
	end else begin : g_val_ext
		assign in_value = {{(VALUE_BITS-IN_VALUE_W){1'b0}}, s_tdata};
	end

	assign in_ovf = ovf_seen_q || (fill_q == FULL);

	// sequence bookkeeping at the entry
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q     <= '0;
			ovf_seen_q <= 1'b0;
			ctl_s1     <= '0;
		end else if (adv) begin
			ctl_s1.valid <= s_tvalid;
			ctl_s1.last  <= s_tlast;
			ctl_s1.ovf   <= in_ovf;
			if (accept) begin
				if (s_tlast) begin
					fill_q     <= '0;
					ovf_seen_q <= 1'b0;
				end else begin
					ovf_seen_q <= in_ovf;
					if (fill_q != FULL) begin
						fill_q <= fill_q + PW'(1);
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			value_s1 <= in_value;
			pos_s1   <= fill_q;
		end
	end

	assign ctl_c[0]   = ctl_s1;
	assign value_c[0] = value_s1;
	assign pos_c[0]   = pos_s1;
	assign sum_c[0]   = '0;
	assign below_c[0] = '0;
	assign above_c[0] = '0;

	for (genvar j = 0; j < MAX_ITEMS; j++) begin : g_cell
		mtc_cell #(
			.MAX_ITEMS (MAX_ITEMS),
			.VALUE_BITS(VALUE_BITS),
			.CELL_IDX  (j)
		) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.adv    (adv),
			.ctl_i  (ctl_c[j]),
			.value_i(value_c[j]),
			.pos_i  (pos_c[j]),
			.sum_i  (sum_c[j]),
			.below_i(below_c[j]),
			.above_i(above_c[j]),
			.ctl_o  (ctl_c[j+1]),
			.value_o(value_c[j+1]),
			.pos_o  (pos_c[j+1]),
			.sum_o  (sum_c[j+1]),
			.below_o(below_c[j+1]),
			.above_o(above_c[j+1])
		);
	end

	// an ignored item leaves the total as it is
	assign result = ctl_c[MAX_ITEMS].ovf ? total_q : sat_add(total_q, sum_c[MAX_ITEMS]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			total_q     <= '0;
		end else if (adv) begin
			out_valid_q <= ctl_c[MAX_ITEMS].valid;
			if (ctl_c[MAX_ITEMS].valid) begin
				total_q <= ctl_c[MAX_ITEMS].last ? '0 : result;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv && ctl_c[MAX_ITEMS].valid) begin
			team_q     <= result;
			out_ovf_q  <= ctl_c[MAX_ITEMS].ovf;
			out_last_q <= ctl_c[MAX_ITEMS].last;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{(OUT_DATA_W-TOTAL_W){1'b0}}, team_q};
	assign m_tuser  = out_ovf_q;
	assign m_tlast  = out_last_q;

endmodule

@@ bench/tb_monotone_triple_counter_core.sv @@
module tb_monotone_triple_counter_core;
	import mtc_pkg::*;

	localparam int DEPTH      = mtc_pkg::MAX_ITEMS_DEF;
	localparam int ITEM_GOAL  = 950;
	localparam int IDLE_LIMIT = 5000;
	localparam int LONG_HOLD  = 700;

	typedef enum int {
		VAL_FULL,
		VAL_NARROW,
		VAL_EXTREME,
		VAL_MIDDLE
	} value_mode_e;

	// running tally of monotone triples, one expectation per accepted item
	class triple_scoreboard;
		typedef struct {
			logic [TOTAL_W-1:0] count;
			logic               ovf;
			logic               last;
		} tally_t;

		tally_t             tallies[$];
		logic [15:0]        vals[DEPTH];
		int unsigned        below_cnt[DEPTH];
		int unsigned        above_cnt[DEPTH];
		int unsigned        fill;
		logic [TOTAL_W-1:0] total;
		logic               ovf_seen;
		int                 errors;
		int                 checked;

		function new();
			fill = 0;
			total = '0;
			ovf_seen = 1'b0;
			errors = 0;
			checked = 0;
		endfunction

		function int pending();
			return tallies.size();
		endfunction

		function void note_item(logic [15:0] v, logic lst);
			tally_t      t;
			longint      sum;
			int unsigned below;
			int unsigned above;
			if (fill >= DEPTH) begin
				ovf_seen = 1'b1;
			end else begin
				sum = total;
				below = 0;
				above = 0;
				for (int j = 0; j < fill; j++) begin
					if (vals[j] < v) begin
						sum += below_cnt[j];
						below++;
					end else if (vals[j] > v) begin
						sum += above_cnt[j];
						above++;
					end
				end
				if (sum > longint'(TOTAL_MAX))
					sum = TOTAL_MAX;
				total = sum[TOTAL_W-1:0];
				vals[fill] = v;
				below_cnt[fill] = below;
				above_cnt[fill] = above;
				fill++;
			end
			t.count = total;
			t.ovf = ovf_seen;
			t.last = lst;
			tallies.push_back(t);
			if (lst) begin
				fill = 0;
				total = '0;
				ovf_seen = 1'b0;
			end
		endfunction

		task report_mismatch(string msg);
			$display("MISMATCH at %0t: %s", $realtime, msg);
			errors++;
		endtask

		task check_result(logic [OUT_DATA_W-1:0] data, logic user, logic lst);
			tally_t t;
			if (tallies.size() == 0) begin
				report_mismatch($sformatf("result %0h with nothing outstanding", data));
				return;
			end
			t = tallies.pop_front();
			checked++;
			if (data !== {{(OUT_DATA_W-TOTAL_W){1'b0}}, t.count})
				report_mismatch($sformatf("result %0d: count %0d, want %0d",
					checked, data, t.count));
			if (user !== t.ovf)
				report_mismatch($sformatf("result %0d: overflow %b, want %b",
					checked, user, t.ovf));
			if (lst !== t.last)
				report_mismatch($sformatf("result %0d: last %b, want %b",
					checked, lst, t.last));
		endtask
	endclass

	logic                  clk;
	logic                  arst_n;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [IN_VALUE_W-1:0] s_tdata;
	logic                  s_tlast;
	logic                  m_tvalid;
	logic                  m_tready;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic                  m_tuser;
	logic                  m_tlast;

	triple_scoreboard sb;
	int  items_sent;
	int  seqs_sent;
	int  ovf_items;
	bit  long_hold_go;

	monotone_triple_counter_core u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// mostly short gaps, now and then a long one
	function automatic int draw_gap();
		if ($urandom_range(0, 19) == 0)
			return $urandom_range(12, 50);
		return $urandom_range(1, 3);
	endfunction

	function automatic logic [15:0] draw_value(value_mode_e mode);
		case (mode)
			VAL_NARROW:  return 16'($urandom_range(0, 7));
			VAL_EXTREME: begin
				case ($urandom_range(0, 3))
					0: return 16'h0000;
					1: return 16'h0001;
					2: return 16'hFFFE;
					default: return 16'hFFFF;
				endcase
			end
			VAL_MIDDLE:  return 16'($urandom_range(16'h7FF8, 16'h8007));
			default:     return 16'($urandom_range(0, 16'hFFFF));
		endcase
	endfunction

	// entered and left at a falling edge
	task automatic send_item(logic [15:0] v, logic lst, int gap);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= v;
		s_tlast <= lst;
		do
			@(posedge clk);
		while (!s_tready);
		sb.note_item(v, lst);
		items_sent++;
		@(negedge clk);
	endtask

	task automatic send_seq(logic [15:0] seq[$]);
		foreach (seq[k])
			send_item(seq[k], k == seq.size() - 1, $urandom_range(0, 1));
		seqs_sent++;
	endtask

	// hold the input idle until every outstanding total has come back
	task automatic drain_results();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (sb.pending() > 0)
			@(posedge clk);
		@(negedge clk);
	endtask

	// output side: random stalls, quiet stretches, one long hold on request
	initial begin
		int hold_left;
		int stall_left;
		int quiet_left;
		hold_left = 0;
		stall_left = 0;
		quiet_left = 0;
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (long_hold_go) begin
				long_hold_go = 1'b0;
				hold_left = LONG_HOLD;
			end
			if (quiet_left > 0)
				quiet_left--;
			else if ($urandom_range(0, 199) == 0)
				quiet_left = $urandom_range(50, 200);
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
				if (quiet_left == 0 && $urandom_range(0, 3) == 0)
					stall_left = draw_gap();
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			sb.check_result(m_tdata, m_tuser, m_tlast);
	end

	// end the run when nothing moves on either side for too long
	initial begin
		int idle;
		idle = 0;
		forever begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				idle = 0;
			else
				idle++;
			if (idle >= IDLE_LIMIT)
				break;
		end
		$display("Stalled: nothing accepted for %0d cycles, %0d totals outstanding",
			IDLE_LIMIT, sb.pending());
		$display("Regression FAIL");
		$finish;
	end

	initial begin
		int          len;
		int          seq_idx;
		bit          burst;
		value_mode_e mode;
		sb = new();
		items_sent = 0;
		seqs_sent = 0;
		ovf_items = 0;
		long_hold_go = 1'b0;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tlast = 1'b0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// lone item, rising run, falling run, all equal, mixed with ties
		send_seq('{16'hFFFF});
		send_seq('{16'h0000, 16'h0001, 16'h7FFF, 16'h8000, 16'hFFFF});
		send_seq('{16'hFFFF, 16'h8000, 16'h0001, 16'h0000});
		send_seq('{16'h5A5A, 16'h5A5A, 16'h5A5A, 16'hA5A5 ^ 16'hFFFF});
		send_seq('{16'h0003, 16'h0001, 16'h0003, 16'h0002, 16'h0001, 16'h0003, 16'h0000});

		seq_idx = 0;
		while (items_sent < ITEM_GOAL) begin
			if (seq_idx == 2 || seq_idx == 9 || $urandom_range(0, 24) == 0)
				len = $urandom_range(DEPTH - 6, DEPTH + 16);
			else
				len = $urandom_range(1, 40);
			mode = value_mode_e'($urandom_range(0, 3));
			burst = ($urandom_range(0, 3) == 0);
			for (int i = 0; i < len; i++) begin
				// long output hold while the input keeps offering items
				if (seq_idx == 2 && i == 10)
					long_hold_go = 1'b1;
				if (seq_idx == 6 && i == len / 2)
					drain_results();
				if (i >= DEPTH)
					ovf_items++;
				send_item(draw_value(mode), i == len - 1,
					(burst || $urandom_range(0, 2) != 0) ? 0 : draw_gap());
			end
			seqs_sent++;
			seq_idx++;
		end
		s_tvalid <= 1'b0;

		while (sb.pending() > 0)
			@(posedge clk);
		repeat (DEPTH + 20) @(posedge clk);

		$display("Sent %0d items in %0d sequences, %0d of them past a full store.",
			items_sent, seqs_sent, ovf_items);
		$display("Checked %0d totals with %0d mismatches.", sb.checked, sb.errors);
		if (sb.errors == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
